// ===== sv/sactc_pkg.sv =====
// shared types and constants of the set-associative cache tag controller
package sactc_pkg;

   localparam int ADDR_W = 32;
   localparam int TAG_W = 32;
   localparam int MODE_W = 2;
   localparam int OUT_SET_W = 8;
   localparam int OUT_WAY_W = 2;
   localparam int OUT_MWR_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [MODE_W-1:0] MODE_READ = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INSTR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_BACK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ALLOCATE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 3'd4;

   localparam logic REPL_LRU = 1'b0;
   localparam logic REPL_FIFO = 1'b1;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic                 hit;
      logic                 allocated;
      logic                 evicted;
      logic                 dirty_writeback;
      logic [OUT_WAY_W-1:0] way;
      logic                 memory_read;
      logic [OUT_MWR_W-1:0] mem_write_count;
   } rsp_type;

   typedef struct packed {
      logic replacement_mode;
      logic write_back;
      logic write_allocate;
   } policy_type;

endpackage

// ===== sv/sactc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module sactc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sactc_lookup.sv =====
// tag match, victim choice and rank update of one set row
module sactc_lookup #(
   parameter int WAYS = 4,
   parameter int RANK_W = 2,
   parameter int WAY_W = 2
) (
   input  logic [WAYS-1:0]                          valid_row,
   input  logic [WAYS-1:0]                          dirty_row,
   input  logic [WAYS-1:0][sactc_pkg::TAG_W-1:0]    tag_row,
   input  logic [WAYS-1:0][RANK_W-1:0]              lru_row,
   input  logic [WAYS-1:0][RANK_W-1:0]              fifo_row,
   input  logic [sactc_pkg::TAG_W-1:0]              tag,
   input  logic                                     is_write,
   input  sactc_pkg::policy_type                    policy,
   output logic [WAYS-1:0]                          valid_new,
   output logic [WAYS-1:0]                          dirty_new,
   output logic [WAYS-1:0][sactc_pkg::TAG_W-1:0]    tag_new,
   output logic [WAYS-1:0][RANK_W-1:0]              lru_new,
   output logic [WAYS-1:0][RANK_W-1:0]              fifo_new,
   output sactc_pkg::rsp_type                       rsp
);

   import sactc_pkg::*;

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
   localparam logic [RANK_W:0] RANK_NONE = (RANK_W + 1)'(WAYS);

   logic [WAYS-1:0]  match;
   logic             hit;
   logic [WAY_W-1:0] hit_way;
   logic             any_invalid;
   logic [WAY_W-1:0] invalid_way;
   logic [WAY_W-1:0] oldest_way;
   logic [WAY_W-1:0] victim;
   logic             alloc;
   logic             around;
   logic [WAY_W-1:0] target;
   logic             was_valid;
   logic             was_dirty;
   logic [RANK_W:0]  lru_old;
   logic [RANK_W:0]  fifo_old;
   logic             wb;
   logic             wt;

   always_comb begin
      hit_way = '0;
      invalid_way = '0;
      oldest_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match[w] = valid_row[w] && (tag_row[w] == tag);
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!valid_row[w]) begin
            invalid_way = WAY_W'(w);
         end
         if (policy.replacement_mode == REPL_FIFO) begin
            if (fifo_row[w] == RANK_MAX) begin
               oldest_way = WAY_W'(w);
            end
         end else begin
            if (lru_row[w] == RANK_MAX) begin
               oldest_way = WAY_W'(w);
            end
         end
      end
      hit = |match;
      any_invalid = ~&valid_row;
      victim = any_invalid ? invalid_way : oldest_way;
      around = !hit && is_write && !policy.write_allocate;
      alloc = !hit && !around;
      target = hit ? hit_way : victim;
      was_valid = valid_row[target];
      was_dirty = dirty_row[target];
      lru_old = was_valid ? {1'b0, lru_row[target]} : RANK_NONE;
      fifo_old = was_valid ? {1'b0, fifo_row[target]} : RANK_NONE;
      wb = alloc && was_valid && was_dirty;
      wt = is_write && !policy.write_back && (hit || alloc);
   end

   always_comb begin
      valid_new = valid_row;
      dirty_new = dirty_row;
      tag_new = tag_row;
      lru_new = lru_row;
      fifo_new = fifo_row;
      if (hit || alloc) begin
         for (int w = 0; w < WAYS; w++) begin
            if ((WAY_W'(w) != target) && valid_row[w]) begin
               if (({1'b0, lru_row[w]} < lru_old) && (lru_row[w] < RANK_MAX)) begin
                  lru_new[w] = lru_row[w] + 1'b1;
               end
               if (alloc && ({1'b0, fifo_row[w]} < fifo_old) &&
                   (fifo_row[w] < RANK_MAX)) begin
                  fifo_new[w] = fifo_row[w] + 1'b1;
               end
            end
         end
         lru_new[target] = '0;
      end
      if (alloc) begin
         fifo_new[target] = '0;
         valid_new[target] = 1'b1;
         tag_new[target] = tag;
         dirty_new[target] = is_write && policy.write_back;
      end else if (hit && is_write && policy.write_back) begin
         dirty_new[target] = 1'b1;
      end
   end

   always_comb begin
      rsp.hit = hit;
      rsp.allocated = alloc;
      rsp.evicted = alloc && was_valid;
      rsp.dirty_writeback = wb;
      rsp.way = around ? '0 : OUT_WAY_W'(target);
      rsp.memory_read = alloc;
      rsp.mem_write_count = OUT_MWR_W'(wb) + OUT_MWR_W'(wt) + OUT_MWR_W'(around);
   end

endmodule

// ===== sv/set_associative_cache_tag_controller.sv =====
// top level of the set-associative cache tag controller
// rsp_strobe is registered from s1_valid_ff, which the accepting edge sets (ram read, then update)
// throughput: one request per cycle while busy is low; a set written in the previous cycle is forwarded
// reset: a clearing pass writes every set row while busy is high
// configuration registers return to their reset values at reset
// results are shown for one cycle on rsp_strobe, the receiver cannot stall
module set_associative_cache_tag_controller #(
   parameter int WAYS = 4,
   parameter int SETS = 256,
   parameter int ADDR_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sactc_pkg::ADDR_W-1:0]        req_address,
   input  logic [sactc_pkg::MODE_W-1:0]        req_mode,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic                                rsp_allocated,
   output logic                                rsp_evicted,
   output logic                                rsp_dirty_writeback,
   output logic [sactc_pkg::OUT_SET_W-1:0]     rsp_set_addr,
   output logic [sactc_pkg::OUT_WAY_W-1:0]     rsp_way,
   output logic [sactc_pkg::TAG_W-1:0]         rsp_tag,
   output logic                                rsp_memory_read,
   output logic [sactc_pkg::OUT_MWR_W-1:0]     rsp_mem_write_count,
   input  logic                                csr_write,
   input  logic [sactc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sactc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import sactc_pkg::*;

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W = RANK_W;
   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int LOG_SETS = (SETS > 1) ? $clog2(SETS) : 0;
   localparam int ROW_W = WAYS * (2 + TAG_W + 2 * RANK_W);
   localparam logic [CSR_DATA_W-1:0] MAX_SB = CSR_DATA_W'(LOG_SETS);
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   // configuration
   logic                  repl_mode_ff;
   logic                  write_back_ff;
   logic                  write_alloc_ff;
   logic [CSR_DATA_W-1:0] block_shift_ff;
   logic [CSR_DATA_W-1:0] set_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_mode_ff <= REPL_LRU;
         write_back_ff <= 1'b1;
         write_alloc_ff <= 1'b1;
         block_shift_ff <= CSR_DATA_W'(6);
         set_bits_ff <= CSR_DATA_W'(8);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_REPLACEMENT_MODE: repl_mode_ff <= csr_wdata[0];
            CSR_WRITE_BACK:       write_back_ff <= csr_wdata[0];
            CSR_WRITE_ALLOCATE:   write_alloc_ff <= csr_wdata[0];
            CSR_BLOCK_SHIFT:      block_shift_ff <= csr_wdata;
            CSR_SET_BITS:         set_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing pass control
   state_type        state_ff;
   state_type        state_in;
   logic [SET_W-1:0] clear_ff;
   logic [SET_W-1:0] clear_in;
   logic             clearing;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clear_ff == LAST_SET) begin
            state_in = ST_RUN;
         end
         ST_RUN: state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing = 1'b0;
      clear_in = clear_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            clear_in = clear_ff + 1'b1;
         end
         ST_RUN: clearing = 1'b0;
         default: clearing = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
      end
   end

   assign busy = clearing;

   // request decode
   logic                  accept;
   logic [ADDR_W-1:0]     addr_masked;
   logic [ADDR_W-1:0]     block_addr;
   logic [CSR_DATA_W-1:0] sb;
   logic [ADDR_W-1:0]     set_full;
   logic [SET_W-1:0]      req_set;
   logic [TAG_W-1:0]      req_tag;

   always_comb begin
      accept = start && !busy;
      addr_masked = req_address & ADDR_MASK;
      sb = (set_bits_ff > MAX_SB) ? MAX_SB : set_bits_ff;
      block_addr = addr_masked >> block_shift_ff;
      set_full = block_addr & ~({ADDR_W{1'b1}} << sb);
      req_set = SET_W'(set_full);
      req_tag = TAG_W'(block_addr >> sb);
   end

   // lookup stage
   logic             s1_valid_ff;
   logic [SET_W-1:0] s1_set_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic             s1_write_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_set_ff <= req_set;
         s1_tag_ff <= req_tag;
         s1_write_ff <= (req_mode == MODE_WRITE);
      end
   end

   // set row storage with forwarding of the row written in the previous cycle
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] cur_row;
   logic [ROW_W-1:0] new_row;
   logic             fwd_valid_ff;
   logic [SET_W-1:0] fwd_set_ff;
   logic [ROW_W-1:0] fwd_row_ff;
   logic             ram_we;
   logic [SET_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;

   always_comb begin
      ram_we = clearing || s1_valid_ff;
      ram_waddr = clearing ? clear_ff : s1_set_ff;
      ram_wdata = clearing ? '0 : new_row;
   end

   sactc_ram #(
      .WIDTH(ROW_W),
      .DEPTH(SETS)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(req_set),
      .rd_data(rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_set_ff <= s1_set_ff;
      fwd_row_ff <= new_row;
   end

   assign cur_row = (fwd_valid_ff && (fwd_set_ff == s1_set_ff)) ? fwd_row_ff : rd_row;

   logic [WAYS-1:0]             valid_row;
   logic [WAYS-1:0]             dirty_row;
   logic [WAYS-1:0][TAG_W-1:0]  tag_row;
   logic [WAYS-1:0][RANK_W-1:0] lru_row;
   logic [WAYS-1:0][RANK_W-1:0] fifo_row;
   logic [WAYS-1:0]             valid_new;
   logic [WAYS-1:0]             dirty_new;
   logic [WAYS-1:0][TAG_W-1:0]  tag_new;
   logic [WAYS-1:0][RANK_W-1:0] lru_new;
   logic [WAYS-1:0][RANK_W-1:0] fifo_new;
   policy_type                  policy;
   rsp_type                     rsp;

   assign {valid_row, dirty_row, tag_row, lru_row, fifo_row} = cur_row;
   assign new_row = {valid_new, dirty_new, tag_new, lru_new, fifo_new};

   always_comb begin
      policy.replacement_mode = repl_mode_ff;
      policy.write_back = write_back_ff;
      policy.write_allocate = write_alloc_ff;
   end

   sactc_lookup #(
      .WAYS  (WAYS),
      .RANK_W(RANK_W),
      .WAY_W (WAY_W)
   ) u_lookup (
      .valid_row(valid_row),
      .dirty_row(dirty_row),
      .tag_row  (tag_row),
      .lru_row  (lru_row),
      .fifo_row (fifo_row),
      .tag      (s1_tag_ff),
      .is_write (s1_write_ff),
      .policy   (policy),
      .valid_new(valid_new),
      .dirty_new(dirty_new),
      .tag_new  (tag_new),
      .lru_new  (lru_new),
      .fifo_new (fifo_new),
      .rsp      (rsp)
   );

   // result register
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic [OUT_SET_W-1:0] rsp_set_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_ff <= rsp;
         rsp_set_ff <= OUT_SET_W'(s1_set_ff);
         rsp_tag_ff <= s1_tag_ff;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_hit = rsp_ff.hit;
   assign rsp_allocated = rsp_ff.allocated;
   assign rsp_evicted = rsp_ff.evicted;
   assign rsp_dirty_writeback = rsp_ff.dirty_writeback;
   assign rsp_set_addr = rsp_set_ff;
   assign rsp_way = rsp_ff.way;
   assign rsp_tag = rsp_tag_ff;
   assign rsp_memory_read = rsp_ff.memory_read;
   assign rsp_mem_write_count = rsp_ff.mem_write_count;

endmodule

// ===== test/sactc_lookup_checker.sv =====
// checker that predicts each cache lookup result and compares it with the block output
module sactc_lookup_checker #(
   parameter int WAYS = 4,
   parameter int SETS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [sactc_pkg::ADDR_W-1:0]        req_address,
   input  logic [sactc_pkg::MODE_W-1:0]        req_mode,
   input  logic                                rsp_strobe,
   input  logic                                rsp_hit,
   input  logic                                rsp_allocated,
   input  logic                                rsp_evicted,
   input  logic                                rsp_dirty_writeback,
   input  logic [sactc_pkg::OUT_SET_W-1:0]     rsp_set_addr,
   input  logic [sactc_pkg::OUT_WAY_W-1:0]     rsp_way,
   input  logic [sactc_pkg::TAG_W-1:0]         rsp_tag,
   input  logic                                rsp_memory_read,
   input  logic [sactc_pkg::OUT_MWR_W-1:0]     rsp_mem_write_count,
   input  logic                                csr_write,
   input  logic [sactc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sactc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  errors,
   output int                                  pending,
   output int                                  checked,
   output int                                  hit_count,
   output int                                  writeback_count
);
   import sactc_pkg::*;

   localparam int SET_BITS_MAX = $clog2(SETS);
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINES = SETS * WAYS;

   typedef struct packed {
      logic                 hit;
      logic                 allocated;
      logic                 evicted;
      logic                 dirty_writeback;
      logic [OUT_SET_W-1:0] set_addr;
      logic [OUT_WAY_W-1:0] way;
      logic [TAG_W-1:0]     tag;
      logic                 memory_read;
      logic [OUT_MWR_W-1:0] mem_write_count;
   } lookup_result_type;

   bit              line_valid [LINES];
   bit              line_dirty [LINES];
   bit [TAG_W-1:0]  line_tag [LINES];
   bit [RANK_W-1:0] recency_rank [LINES];
   bit [RANK_W-1:0] fill_rank [LINES];

   bit       fifo_policy;
   bit       write_back_on;
   bit       write_allocate_on;
   bit [3:0] block_shift_cfg;
   bit [3:0] set_bits_cfg;

   lookup_result_type expected_lookups[$];

   // make way w the newest; valid ways younger than its old age grow one older
   task automatic age_ways(input bit fill_order, input int base, input int w,
                           input bit was_valid);
      int old_age;
      int age;
      old_age = WAYS;
      if (was_valid) begin
         old_age = fill_order ? int'(fill_rank[base + w]) : int'(recency_rank[base + w]);
      end
      for (int i = 0; i < WAYS; i++) begin
         if (i != w && line_valid[base + i]) begin
            age = fill_order ? int'(fill_rank[base + i]) : int'(recency_rank[base + i]);
            if (age < old_age && age < WAYS - 1) begin
               if (fill_order) fill_rank[base + i] = RANK_W'(age + 1);
               else recency_rank[base + i] = RANK_W'(age + 1);
            end
         end
      end
      if (fill_order) fill_rank[base + w] = '0;
      else recency_rank[base + w] = '0;
   endtask

   function automatic int choose_victim(input int base);
      int best;
      best = 0;
      for (int i = 0; i < WAYS; i++)
         if (!line_valid[base + i]) return i;
      for (int i = 1; i < WAYS; i++) begin
         if (fifo_policy ? (fill_rank[base + i] > fill_rank[base + best])
                         : (recency_rank[base + i] > recency_rank[base + best]))
            best = i;
      end
      return best;
   endfunction

   task automatic predict_lookup(input logic [ADDR_W-1:0] addr,
                                 input logic [MODE_W-1:0] kind,
                                 output lookup_result_type res);
      logic [31:0] block;
      logic [31:0] set_num;
      logic [31:0] tag_val;
      int sb;
      int base;
      int victim;
      bit is_write;
      bit found;
      bit was_valid;
      is_write = (kind == MODE_WRITE);
      sb = (int'(set_bits_cfg) > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_cfg);
      block = addr >> block_shift_cfg;
      set_num = block & ((32'd1 << sb) - 32'd1);
      tag_val = block >> sb;
      base = set_num * WAYS;
      found = 1'b0;
      res = '0;
      res.set_addr = set_num[OUT_SET_W-1:0];
      res.tag = tag_val;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && line_valid[base + w] && line_tag[base + w] == tag_val) begin
            found = 1'b1;
            res.hit = 1'b1;
            res.way = OUT_WAY_W'(w);
            age_ways(1'b0, base, w, 1'b1);
            if (is_write) begin
               if (write_back_on) line_dirty[base + w] = 1'b1;
               else res.mem_write_count = OUT_MWR_W'(1);
            end
         end
      end
      if (!found) begin
         if (is_write && !write_allocate_on) begin
            res.mem_write_count = OUT_MWR_W'(1);
         end else begin
            victim = choose_victim(base);
            was_valid = line_valid[base + victim];
            res.allocated = 1'b1;
            res.memory_read = 1'b1;
            res.way = OUT_WAY_W'(victim);
            res.evicted = was_valid;
            res.dirty_writeback = was_valid && line_dirty[base + victim];
            res.mem_write_count = {1'b0, res.dirty_writeback};
            age_ways(1'b0, base, victim, was_valid);
            age_ways(1'b1, base, victim, was_valid);
            line_valid[base + victim] = 1'b1;
            line_dirty[base + victim] = is_write && write_back_on;
            line_tag[base + victim] = tag_val;
            if (is_write && !write_back_on) begin
               res.mem_write_count = res.mem_write_count + OUT_MWR_W'(1);
            end
         end
      end
   endtask

   task automatic show_lookup(input string label, input lookup_result_type v);
      $display("%s hit=%0b alloc=%0b evict=%0b wb=%0b set=%0d way=%0d tag=%h mrd=%0b mwr=%0d",
               label, v.hit, v.allocated, v.evicted, v.dirty_writeback, v.set_addr,
               v.way, v.tag, v.memory_read, v.mem_write_count);
   endtask

   always @(posedge clock) begin : monitor
      lookup_result_type seen;
      lookup_result_type want;
      if (reset) begin
         fifo_policy = REPL_LRU;
         write_back_on = 1'b1;
         write_allocate_on = 1'b1;
         block_shift_cfg = 4'd6;
         set_bits_cfg = 4'd8;
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tag[i] = '0;
            recency_rank[i] = '0;
            fill_rank[i] = '0;
         end
         expected_lookups.delete();
      end else begin
         if (rsp_strobe) begin
            seen.hit = rsp_hit;
            seen.allocated = rsp_allocated;
            seen.evicted = rsp_evicted;
            seen.dirty_writeback = rsp_dirty_writeback;
            seen.set_addr = rsp_set_addr;
            seen.way = rsp_way;
            seen.tag = rsp_tag;
            seen.memory_read = rsp_memory_read;
            seen.mem_write_count = rsp_mem_write_count;
            if (expected_lookups.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("result with no request outstanding");
                  show_lookup("  actual  ", seen);
               end
            end else begin
               want = expected_lookups.pop_front();
               checked++;
               if (want.hit) hit_count++;
               if (want.dirty_writeback) writeback_count++;
               if (seen !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("lookup mismatch on result %0d", checked);
                     show_lookup("  expected", want);
                     show_lookup("  actual  ", seen);
                  end
               end
            end
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_REPLACEMENT_MODE: fifo_policy = csr_wdata[0];
               CSR_WRITE_BACK: write_back_on = csr_wdata[0];
               CSR_WRITE_ALLOCATE: write_allocate_on = csr_wdata[0];
               CSR_BLOCK_SHIFT: block_shift_cfg = csr_wdata;
               CSR_SET_BITS: set_bits_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            predict_lookup(req_address, req_mode, want);
            expected_lookups.insert(expected_lookups.size(), want);
         end
      end
      pending = expected_lookups.size();
   end

endmodule

// ===== test/set_associative_cache_tag_controller_tb.sv =====
// testbench top: clock, reset, request and policy stimulus, and the final verdict
module set_associative_cache_tag_controller_tb;
   import sactc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SET_BITS_MAX = 8;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_REQUESTS = 125;
   localparam int TAIL_CYCLES = 6;
   localparam int CYCLE_LIMIT = 500000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ADDR_W-1:0]     req_address;
   logic [MODE_W-1:0]     req_mode;
   logic                  rsp_strobe;
   logic                  rsp_hit;
   logic                  rsp_allocated;
   logic                  rsp_evicted;
   logic                  rsp_dirty_writeback;
   logic [OUT_SET_W-1:0]  rsp_set_addr;
   logic [OUT_WAY_W-1:0]  rsp_way;
   logic [TAG_W-1:0]      rsp_tag;
   logic                  rsp_memory_read;
   logic [OUT_MWR_W-1:0]  rsp_mem_write_count;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int errors;
   int pending;
   int checked;
   int hit_count;
   int writeback_count;
   int cycle_count = 0;
   int requests = 0;
   int settings = 0;
   int cur_bs = 6;
   int cur_sb = 8;
   logic [7:0]  set_pool [3];
   logic [31:0] tag_pool [6];

   set_associative_cache_tag_controller dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_address(req_address),
      .req_mode(req_mode),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_allocated(rsp_allocated),
      .rsp_evicted(rsp_evicted),
      .rsp_dirty_writeback(rsp_dirty_writeback),
      .rsp_set_addr(rsp_set_addr),
      .rsp_way(rsp_way),
      .rsp_tag(rsp_tag),
      .rsp_memory_read(rsp_memory_read),
      .rsp_mem_write_count(rsp_mem_write_count),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   sactc_lookup_checker u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_address(req_address),
      .req_mode(req_mode),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_allocated(rsp_allocated),
      .rsp_evicted(rsp_evicted),
      .rsp_dirty_writeback(rsp_dirty_writeback),
      .rsp_set_addr(rsp_set_addr),
      .rsp_way(rsp_way),
      .rsp_tag(rsp_tag),
      .rsp_memory_read(rsp_memory_read),
      .rsp_mem_write_count(rsp_mem_write_count),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .errors(errors),
      .pending(pending),
      .checked(checked),
      .hit_count(hit_count),
      .writeback_count(writeback_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // start stays high on return so back-to-back requests need no second assignment
   task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [MODE_W-1:0] kind);
      start <= 1'b1;
      req_address <= addr;
      req_mode <= kind;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      requests++;
   endtask

   task automatic sender_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = 0;
      if (r >= 90) n = $urandom_range(8, 40);
      else if (r >= 55) n = $urandom_range(1, 3);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // one-bit registers get random upper data bits
   function automatic logic [CSR_DATA_W-1:0] with_noise(input logic b);
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'($urandom);
      d[0] = b;
      return d;
   endfunction

   task automatic program_policy(input logic repl, input logic wb, input logic wa,
                                 input logic [3:0] bs, input logic [3:0] sb);
      logic [CSR_IDX_W-1:0] spare;
      write_register(CSR_REPLACEMENT_MODE, with_noise(repl));
      write_register(CSR_WRITE_BACK, with_noise(wb));
      write_register(CSR_WRITE_ALLOCATE, with_noise(wa));
      write_register(CSR_BLOCK_SHIFT, bs);
      write_register(CSR_SET_BITS, sb);
      if ($urandom_range(0, 1)) begin
         spare = CSR_IDX_W'($urandom_range(CSR_SET_BITS + 1, {CSR_IDX_W{1'b1}}));
         write_register(spare, CSR_DATA_W'($urandom));
      end
      csr_write <= 1'b0;
      cur_bs = int'(bs);
      cur_sb = (int'(sb) > SET_BITS_MAX) ? SET_BITS_MAX : int'(sb);
      settings++;
   endtask

   function automatic logic [ADDR_W-1:0] make_address(input logic [7:0] set_num,
                                                      input logic [31:0] tag_val);
      logic [31:0] block;
      logic [31:0] offset;
      block = (tag_val << cur_sb) | {24'd0, set_num};
      offset = $urandom & ((32'd1 << cur_bs) - 32'd1);
      return (block << cur_bs) | offset;
   endfunction

   initial begin : stimulus
      int r;
      bit quiet;
      logic [ADDR_W-1:0] addr;
      logic [MODE_W-1:0] kind;
      reset = 1'b1;
      start = 1'b0;
      req_address = '0;
      req_mode = MODE_READ;
      csr_write = 1'b0;
      csr_index = CSR_REPLACEMENT_MODE;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset policy: lru, write-back, write-allocate; fill set 0 then evict a dirty line
      send_request(32'h0000_0000, MODE_READ);
      send_request(32'h0000_0000, MODE_READ);
      send_request(32'h0000_0000, MODE_WRITE);
      send_request(32'hFFFF_FFFF, MODE_INSTR);
      send_request(32'h0000_0040, MODE_UNUSED);
      send_request(32'h0000_4000, MODE_WRITE);
      send_request(32'h0000_8000, MODE_WRITE);
      send_request(32'h0000_C000, MODE_READ);
      send_request(32'h0001_0000, MODE_READ);
      send_request(32'h0000_4000, MODE_READ);

      // fifo, write-through, write-around, one set, byte blocks
      drain();
      program_policy(REPL_FIFO, 1'b0, 1'b0, 4'd0, 4'd0);
      send_request(32'h0000_0123, MODE_WRITE);
      send_request(32'h0000_0123, MODE_READ);
      send_request(32'h0000_0123, MODE_WRITE);
      send_request(32'hFFFF_FFFF, MODE_READ);
      send_request(32'h0000_0000, MODE_INSTR);
      send_request(32'h7FFF_FFFF, MODE_UNUSED);
      send_request(32'h8000_0000, MODE_WRITE);
      send_request(32'h0000_0123, MODE_READ);
      send_request(32'h5555_5555, MODE_READ);
      send_request(32'hAAAA_AAAA, MODE_INSTR);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         unique case (p)
            0: program_policy(REPL_LRU, 1'b1, 1'b1, 4'd12, 4'd8);
            1: program_policy(REPL_FIFO, 1'b1, 1'b0, 4'd15, 4'd15);
            2: program_policy(REPL_LRU, 1'b0, 1'b1, 4'd0, 4'd4);
            default: program_policy(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)));
         endcase
         for (int k = 0; k < 3; k++) set_pool[k] = 8'($urandom_range(0, (1 << cur_sb) - 1));
         for (int k = 0; k < 6; k++) tag_pool[k] = $urandom;
         quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) addr = make_address(set_pool[$urandom_range(0, 2)],
                                            tag_pool[$urandom_range(0, 5)]);
            else addr = $urandom;
            kind = MODE_W'($urandom_range(0, 3));
            send_request(addr, kind);
            if (!quiet) sender_gap();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("%0d lookups under %0d policy settings, %0d results checked",
               requests, settings, checked);
      $display("%0d hits and %0d dirty writebacks seen", hit_count, writeback_count);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d failures", errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
